// ===== src/assert_macros.svh =====
// Assertion helpers shared by the RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every clock edge outside reset
`define BRB_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check that a condition never occurs outside reset
`define BRB_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

// ===== src/brb_pkg.sv =====
`timescale 1ns / 1ps

package brb_pkg;

  localparam logic [1:0] REQ_HDR   = 2'd0;
  localparam logic [1:0] REQ_DATA  = 2'd1;
  localparam logic [1:0] REQ_READ  = 2'd2;
  localparam logic [1:0] REQ_CLEAR = 2'd3;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_NO_SPACE = 2'd1;
  localparam logic [1:0] ST_ZERO_LEN = 2'd2;
  localparam logic [1:0] ST_EMPTY    = 2'd3;

  localparam logic [12:0] CAP_RESET = 13'd4096;
  localparam int unsigned CAP_W     = 13;
  localparam int unsigned LEN_W     = 12;

  typedef enum logic [8:0] {
    S_IDLE  = 9'b000000001,
    S_EXEC  = 9'b000000010,
    S_DIFF  = 9'b000000100,
    S_WRAP  = 9'b000001000,
    S_SPACE = 9'b000010000,
    S_CMP   = 9'b000100000,
    S_CLAMP = 9'b001000000,
    S_RADDR = 9'b010000000,
    S_RDATA = 9'b100000000
  } state_t;

endpackage

// ===== src/brb_ram.sv =====
`timescale 1ns / 1ps

module brb_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== src/byte_ring_buffer_records.sv =====
// Write data byte: no transaction on the result side.
// Write header: states EXEC, DIFF, WRAP, SPACE, CMP, then the result is registered; clear: registered in EXEC.
// Read request: setup in EXEC, DIFF, WRAP and CLAMP, then RADDR and RDATA per byte through the store's
// registered read port; the fill-level and free-space arithmetic runs through one shared adder in sequence.
// rst_n (synchronous) zeroes both pointers, drops any pending record and sets
// capacity to 4096; the byte store is not cleared.
`timescale 1ns / 1ps

`include "assert_macros.svh"

module byte_ring_buffer_records
  import brb_pkg::*;
#(
  parameter int unsigned DEPTH    = 4096,
  parameter int unsigned MAX_READ = 64
) (
  input  logic        clk,
  input  logic        rst_n,

  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_req_type,
  input  logic [11:0] in_write_length,
  input  logic [7:0]  in_data_byte,
  input  logic [6:0]  in_read_length,

  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_status,
  output logic [7:0]  out_read_byte,
  output logic [11:0] out_byte_count,
  output logic        out_last,

  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int unsigned PW = $clog2(DEPTH);
  localparam int unsigned CW = PW + 1;
  localparam int unsigned XW = (CW > CAP_W) ? CW : CAP_W;
  localparam int unsigned AW = ((CW > LEN_W) ? CW : LEN_W) + 1;
  localparam logic [6:0]  MAX_RD = 7'(MAX_READ);
  localparam int unsigned CAP_RST = (DEPTH < 32'(CAP_RESET)) ? DEPTH : 32'(CAP_RESET);

  state_t            state_r, state_nxt;
  logic [PW-1:0]     wp_r, wp_nxt;
  logic [PW-1:0]     rp_r, rp_nxt;
  logic [LEN_W-1:0]  btc_r, btc_nxt;
  logic              rec_r, rec_nxt;
  logic [CAP_W-1:0]  cap_r, cap_nxt;
  logic [CW-1:0]     cap_eff_r, cap_eff_nxt;
  logic [AW-1:0]     acc_r, acc_nxt;
  logic [6:0]        n_r, n_nxt;
  logic [6:0]        rem_r, rem_nxt;
  logic [1:0]        req_r, req_nxt;
  logic [LEN_W-1:0]  wlen_r, wlen_nxt;
  logic [7:0]        dbyte_r, dbyte_nxt;
  logic [6:0]        rlenc_r, rlenc_nxt;

  logic              out_valid_r;
  logic [1:0]        out_status_r;
  logic [7:0]        out_read_byte_r;
  logic [11:0]       out_byte_count_r;
  logic              out_last_r;

  logic              out_free;
  logic              out_load;
  logic [1:0]        ld_status;
  logic [7:0]        ld_byte;
  logic [11:0]       ld_count;
  logic              ld_last;

  logic              cfg_wr;
  logic [XW-1:0]     cap_x;
  logic [CW-1:0]     cap_clamp;

  logic [AW-1:0]     alu_a, alu_b, alu_sum;
  logic              alu_inv, alu_cin, alu_neg;

  logic [CW-1:0]     wp_inc, rp_inc;
  logic [PW-1:0]     wp_wrap, rp_wrap;

  logic              ram_we, ram_re;
  logic [7:0]        ram_rdata;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && !paddr[2];
  assign prdata = paddr[2] ? 32'd0 : {{(32 - CAP_W){1'b0}}, cap_r};

  always_comb begin
    cap_x = XW'(pwdata[CAP_W-1:0]);
    if (cap_x < XW'(2)) begin
      cap_clamp = CW'(2);
    end else if (cap_x > XW'(DEPTH)) begin
      cap_clamp = CW'(DEPTH);
    end else begin
      cap_clamp = CW'(cap_x);
    end
  end

  assign wp_inc  = {1'b0, wp_r} + CW'(1);
  assign rp_inc  = {1'b0, rp_r} + CW'(1);
  assign wp_wrap = (wp_inc == cap_eff_r) ? '0 : wp_inc[PW-1:0];
  assign rp_wrap = (rp_inc == cap_eff_r) ? '0 : rp_inc[PW-1:0];

  // shared adder: a + b, a - b with the carry-in set, or a - b - 1 with it clear
  always_comb begin
    alu_a   = '0;
    alu_b   = '0;
    alu_inv = 1'b0;
    alu_cin = 1'b0;
    unique case (state_r)
      S_DIFF: begin
        alu_a   = AW'(wp_r);
        alu_b   = AW'(rp_r);
        alu_inv = 1'b1;
        alu_cin = 1'b1;
      end
      S_WRAP: begin
        alu_a = acc_r;
        alu_b = AW'(cap_eff_r);
      end
      S_SPACE: begin
        alu_a   = AW'(cap_eff_r);
        alu_b   = acc_r;
        alu_inv = 1'b1;
      end
      S_CMP: begin
        alu_a   = acc_r;
        alu_b   = AW'(wlen_r);
        alu_inv = 1'b1;
        alu_cin = 1'b1;
      end
      S_CLAMP: begin
        alu_a   = AW'(rlenc_r);
        alu_b   = acc_r;
        alu_inv = 1'b1;
        alu_cin = 1'b1;
      end
      default: begin
        alu_a = '0;
      end
    endcase
  end

  assign alu_sum = alu_a + (alu_inv ? ~alu_b : alu_b) + AW'(alu_cin);
  assign alu_neg = alu_sum[AW-1];

  assign out_free = !out_valid_r || out_ready;

  always_comb begin
    state_nxt   = state_r;
    wp_nxt      = wp_r;
    rp_nxt      = rp_r;
    btc_nxt     = btc_r;
    rec_nxt     = rec_r;
    cap_nxt     = cap_r;
    cap_eff_nxt = cap_eff_r;
    acc_nxt     = acc_r;
    n_nxt       = n_r;
    rem_nxt     = rem_r;
    req_nxt     = req_r;
    wlen_nxt    = wlen_r;
    dbyte_nxt   = dbyte_r;
    rlenc_nxt   = rlenc_r;
    out_load    = 1'b0;
    ld_status   = ST_OK;
    ld_byte     = '0;
    ld_count    = '0;
    ld_last     = 1'b1;
    ram_we      = 1'b0;
    ram_re      = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          req_nxt   = in_req_type;
          wlen_nxt  = in_write_length;
          dbyte_nxt = in_data_byte;
          rlenc_nxt = (in_read_length > MAX_RD) ? MAX_RD : in_read_length;
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        unique case (req_r)
          REQ_DATA: begin
            if (btc_r != '0) begin
              btc_nxt = btc_r - LEN_W'(1);
              if (rec_r) begin
                ram_we = 1'b1;
                wp_nxt = wp_wrap;
              end
              if (btc_r == LEN_W'(1)) begin
                rec_nxt = 1'b0;
              end
            end
            state_nxt = S_IDLE;
          end
          REQ_CLEAR: begin
            if (out_free) begin
              out_load  = 1'b1;
              wp_nxt    = '0;
              rp_nxt    = '0;
              btc_nxt   = '0;
              rec_nxt   = 1'b0;
              state_nxt = S_IDLE;
            end
          end
          REQ_HDR: begin
            if (wlen_r == '0) begin
              if (out_free) begin
                out_load  = 1'b1;
                ld_status = ST_ZERO_LEN;
                btc_nxt   = '0;
                rec_nxt   = 1'b0;
                state_nxt = S_IDLE;
              end
            end else begin
              state_nxt = S_DIFF;
            end
          end
          REQ_READ: begin
            if (rlenc_r == '0) begin
              if (out_free) begin
                out_load  = 1'b1;
                ld_status = ST_ZERO_LEN;
                state_nxt = S_IDLE;
              end
            end else begin
              state_nxt = S_DIFF;
            end
          end
          default: begin
            state_nxt = S_IDLE;
          end
        endcase
      end
      S_DIFF: begin
        acc_nxt   = alu_sum;
        state_nxt = S_WRAP;
      end
      S_WRAP: begin
        if (acc_r[AW-1]) begin
          acc_nxt = alu_sum;
        end
        state_nxt = (req_r == REQ_HDR) ? S_SPACE : S_CLAMP;
      end
      S_SPACE: begin
        acc_nxt   = alu_sum;
        state_nxt = S_CMP;
      end
      S_CMP: begin
        if (out_free) begin
          out_load = 1'b1;
          btc_nxt  = wlen_r;
          if (alu_neg) begin
            ld_status = ST_NO_SPACE;
            rec_nxt   = 1'b0;
          end else begin
            ld_count = wlen_r;
            rec_nxt  = 1'b1;
          end
          state_nxt = S_IDLE;
        end
      end
      S_CLAMP: begin
        if (acc_r == '0) begin
          if (out_free) begin
            out_load  = 1'b1;
            ld_status = ST_EMPTY;
            state_nxt = S_IDLE;
          end
        end else begin
          n_nxt     = alu_neg ? rlenc_r : acc_r[6:0];
          rem_nxt   = alu_neg ? rlenc_r : acc_r[6:0];
          state_nxt = S_RADDR;
        end
      end
      S_RADDR: begin
        ram_re    = 1'b1;
        rp_nxt    = rp_wrap;
        state_nxt = S_RDATA;
      end
      S_RDATA: begin
        if (out_free) begin
          out_load  = 1'b1;
          ld_byte   = ram_rdata;
          ld_count  = 12'(n_r);
          ld_last   = (rem_r == 7'd1);
          rem_nxt   = rem_r - 7'd1;
          state_nxt = (rem_r == 7'd1) ? S_IDLE : S_RADDR;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    if (cfg_wr) begin
      cap_nxt     = pwdata[CAP_W-1:0];
      cap_eff_nxt = cap_clamp;
      wp_nxt      = '0;
      rp_nxt      = '0;
      btc_nxt     = '0;
      rec_nxt     = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      wp_r        <= '0;
      rp_r        <= '0;
      btc_r       <= '0;
      rec_r       <= 1'b0;
      cap_r       <= CAP_RESET;
      cap_eff_r   <= CW'(CAP_RST);
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      wp_r        <= wp_nxt;
      rp_r        <= rp_nxt;
      btc_r       <= btc_nxt;
      rec_r       <= rec_nxt;
      cap_r       <= cap_nxt;
      cap_eff_r   <= cap_eff_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    acc_r   <= acc_nxt;
    n_r     <= n_nxt;
    rem_r   <= rem_nxt;
    req_r   <= req_nxt;
    wlen_r  <= wlen_nxt;
    dbyte_r <= dbyte_nxt;
    rlenc_r <= rlenc_nxt;
    if (out_load) begin
      out_status_r     <= ld_status;
      out_read_byte_r  <= ld_byte;
      out_byte_count_r <= ld_count;
      out_last_r       <= ld_last;
    end
  end

  brb_ram #(
    .WIDTH (8),
    .DEPTH (DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (wp_r),
    .wdata (dbyte_r),
    .re    (ram_re),
    .raddr (rp_r),
    .rdata (ram_rdata)
  );

  assign in_ready       = (state_r == S_IDLE);
  assign out_valid      = out_valid_r;
  assign out_status     = out_status_r;
  assign out_read_byte  = out_read_byte_r;
  assign out_byte_count = out_byte_count_r;
  assign out_last       = out_last_r;

  `BRB_ASSERT(a_wp_below_cap, ({1'b0, wp_r} < cap_eff_r) && ({1'b0, rp_r} < cap_eff_r), "pointer past capacity")
  `BRB_ASSERT(a_load_when_free, out_load |-> out_free, "result overwritten before transaction")
  `BRB_ASSERT(a_rec_has_bytes, rec_r |-> (btc_r != '0), "record pending with no bytes to come")
  `BRB_NEVER(a_read_underrun, (state_r == S_RDATA) && (rem_r == '0), "read past clamped length")

endmodule

// ===== tb/sv/brb_checker.sv =====
`timescale 1ns / 1ps

module brb_checker
  import brb_pkg::*;
#(
  parameter logic [2:0]  CAP_ADDR = 3'd0,
  parameter int unsigned DEPTH    = 4096,
  parameter int unsigned MAX_READ = 64
) (
  input  logic        clk,
  input  logic        rst_n,

  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [1:0]  in_req_type,
  input  logic [11:0] in_write_length,
  input  logic [7:0]  in_data_byte,
  input  logic [6:0]  in_read_length,

  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [1:0]  out_status,
  input  logic [7:0]  out_read_byte,
  input  logic [11:0] out_byte_count,
  input  logic        out_last,

  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  input  logic        pready,

  output int          err_count,
  output int          pending,
  output int          checked
);

  typedef struct packed {
    logic [1:0]  status;
    logic [7:0]  rd_byte;
    logic [11:0] count;
    logic        last_flag;
  } ring_result_t;

  ring_result_t     due_results[$];
  ring_result_t     got;
  ring_result_t     want;
  logic [7:0]       ring_mem [DEPTH];
  int unsigned      wr_ptr;
  int unsigned      rd_ptr;
  int unsigned      bytes_left;
  logic             keep_record;
  logic [CAP_W-1:0] cap_reg;
  int               errs = 0;
  int               n_checked = 0;

  function automatic int unsigned ring_size();
    int unsigned c;
    c = cap_reg;
    if (c < 2) c = 2;
    if (c > DEPTH) c = DEPTH;
    return c;
  endfunction

  function automatic int unsigned fill_level(input int unsigned cap);
    if (wr_ptr >= rd_ptr) return wr_ptr - rd_ptr;
    return cap - rd_ptr + wr_ptr;
  endfunction

  function automatic void restart_ring();
    wr_ptr      = 0;
    rd_ptr      = 0;
    bytes_left  = 0;
    keep_record = 1'b0;
  endfunction

  function automatic void apply_request(input logic [1:0] req, input logic [11:0] wlen,
                                        input logic [7:0] db, input logic [6:0] rlen);
    int unsigned cap;
    int unsigned room;
    int unsigned avail;
    int unsigned n;
    cap = ring_size();
    case (req)
      REQ_HDR: begin
        room = cap - fill_level(cap) - 1;
        if (wlen == 0) begin
          bytes_left  = 0;
          keep_record = 1'b0;
          due_results.push_back('{ST_ZERO_LEN, 8'd0, 12'd0, 1'b1});
        end else if (room < wlen) begin
          bytes_left  = wlen;
          keep_record = 1'b0;
          due_results.push_back('{ST_NO_SPACE, 8'd0, 12'd0, 1'b1});
        end else begin
          bytes_left  = wlen;
          keep_record = 1'b1;
          due_results.push_back('{ST_OK, 8'd0, wlen, 1'b1});
        end
      end
      REQ_DATA: begin
        if (bytes_left != 0) begin
          bytes_left--;
          if (keep_record) begin
            ring_mem[wr_ptr] = db;
            wr_ptr++;
            if (wr_ptr >= cap) wr_ptr = 0;
          end
          if (bytes_left == 0) keep_record = 1'b0;
        end
      end
      REQ_READ: begin
        avail = fill_level(cap);
        if (rlen == 0) begin
          due_results.push_back('{ST_ZERO_LEN, 8'd0, 12'd0, 1'b1});
        end else if (avail == 0) begin
          due_results.push_back('{ST_EMPTY, 8'd0, 12'd0, 1'b1});
        end else begin
          n = rlen;
          if (n > MAX_READ) n = MAX_READ;
          if (n > avail) n = avail;
          for (int unsigned k = 0; k < n; k++) begin
            due_results.push_back('{ST_OK, ring_mem[rd_ptr], 12'(n), (k + 1 == n)});
            rd_ptr++;
            if (rd_ptr >= cap) rd_ptr = 0;
          end
        end
      end
      default: begin
        restart_ring();
        due_results.push_back('{ST_OK, 8'd0, 12'd0, 1'b1});
      end
    endcase
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      due_results.delete();
      cap_reg = CAP_RESET;
      restart_ring();
    end else begin
      if (out_valid && out_ready) begin
        got = '{out_status, out_read_byte, out_byte_count, out_last};
        if (due_results.size() == 0) begin
          errs++;
          if (errs <= 10)
            $display("%0t: unexpected result status %0d byte %h count %0d last %0b",
                     $time, got.status, got.rd_byte, got.count, got.last_flag);
        end else begin
          want = due_results.pop_front();
          n_checked++;
          if (got.status !== want.status || got.rd_byte !== want.rd_byte ||
              got.count !== want.count || got.last_flag !== want.last_flag) begin
            errs++;
            if (errs <= 10)
              $display({"%0t: mismatch exp/act status %0d/%0d byte %h/%h ",
                        "count %0d/%0d last %0b/%0b"}, $time,
                       want.status, got.status, want.rd_byte, got.rd_byte,
                       want.count, got.count, want.last_flag, got.last_flag);
          end
        end
      end
      if (psel && penable && pwrite && pready && paddr == CAP_ADDR) begin
        cap_reg = pwdata[CAP_W-1:0];
        restart_ring();
      end
      if (in_valid && in_ready)
        apply_request(in_req_type, in_write_length, in_data_byte, in_read_length);
    end
    err_count <= errs;
    pending   <= due_results.size();
    checked   <= n_checked;
  end

endmodule

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top
  import brb_pkg::*;
();

  localparam logic [2:0] CAP_ADDR     = 3'd0;
  localparam int         CYCLE_LIMIT  = 2000000;
  localparam int         DRAIN_CYCLES = 20;
  localparam int         PHASE_ITEMS  = 22;

  logic        clk             = 1'b0;
  logic        rst_n           = 1'b0;
  logic        in_valid        = 1'b0;
  logic        in_ready;
  logic [1:0]  in_req_type     = REQ_CLEAR;
  logic [11:0] in_write_length = 12'd0;
  logic [7:0]  in_data_byte    = 8'd0;
  logic [6:0]  in_read_length  = 7'd0;
  logic        out_valid;
  logic        out_ready       = 1'b0;
  logic [1:0]  out_status;
  logic [7:0]  out_read_byte;
  logic [11:0] out_byte_count;
  logic        out_last;
  logic        psel            = 1'b0;
  logic        penable         = 1'b0;
  logic        pwrite          = 1'b0;
  logic [2:0]  paddr           = 3'd0;
  logic [31:0] pwdata          = 32'd0;
  logic [31:0] prdata;
  logic        pready;

  int          err_count;
  int          pending;
  int          checked;
  int          cycles          = 0;
  int          sent            = 0;
  int          settings        = 0;
  int          cap_eff         = 4096;
  logic        idle_on         = 1'b1;
  int          stall_left      = 0;

  logic [12:0] phase_caps [9] = '{13'd2, 13'd3, 13'd0, 13'd17, 13'd300, 13'd1,
                                  13'd8191, 13'd64, 13'd4096};

  always #5 clk = ~clk;

  always @(posedge clk) cycles <= cycles + 1;

  byte_ring_buffer_records u_top (
    .clk, .rst_n,
    .in_valid, .in_ready, .in_req_type, .in_write_length, .in_data_byte, .in_read_length,
    .out_valid, .out_ready, .out_status, .out_read_byte, .out_byte_count, .out_last,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  brb_checker #(.CAP_ADDR(CAP_ADDR)) u_checker (
    .clk, .rst_n,
    .in_valid, .in_ready, .in_req_type, .in_write_length, .in_data_byte, .in_read_length,
    .out_valid, .out_ready, .out_status, .out_read_byte, .out_byte_count, .out_last,
    .psel, .penable, .pwrite, .paddr, .pwdata, .pready,
    .err_count, .pending, .checked
  );

  // stall the result side in random bursts while idle_on is set
  always @(posedge clk) begin
    if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      out_ready  <= 1'b0;
    end else if (idle_on && $urandom_range(0, 15) == 0) begin
      stall_left <= $urandom_range(0, 18);
      out_ready  <= 1'b0;
    end else begin
      out_ready  <= 1'b1;
    end
  end

  task automatic send(input logic [1:0] req, input int unsigned arg);
    logic [11:0] wl;
    logic [7:0]  db;
    logic [6:0]  rl;
    wl = 12'($urandom);
    db = 8'($urandom);
    rl = 7'($urandom);
    case (req)
      REQ_HDR:  wl = arg[11:0];
      REQ_DATA: db = arg[7:0];
      REQ_READ: rl = arg[6:0];
      default: ;
    endcase
    if (idle_on && $urandom_range(0, 7) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_req_type     <= req;
    in_write_length <= wl;
    in_data_byte    <= db;
    in_read_length  <= rl;
    do @(posedge clk); while (!in_ready);
    sent++;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_capacity(input logic [12:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= CAP_ADDR;
    pwdata  <= {19'd0, val};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    cap_eff = (val < 2) ? 2 : (val > 4096) ? 4096 : val;
    settings++;
  endtask

  initial begin
    while (cycles < CYCLE_LIMIT) @(posedge clk);
    $display("Timeout after %0d cycles with %0d results outstanding", cycles, pending);
    $display("DONE: errors detected");
    $finish;
  end

  initial begin
    int n;
    int pick;
    int len;
    int r;
    int unsigned rl;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send(REQ_READ, 5);
    send(REQ_READ, 0);
    send(REQ_HDR, 0);
    send(REQ_DATA, 8'h3C);
    send(REQ_HDR, 4);
    send(REQ_DATA, 8'h00);
    send(REQ_DATA, 8'hFF);
    send(REQ_DATA, 8'hA5);
    send(REQ_DATA, 8'h5A);
    send(REQ_READ, 127);
    send(REQ_HDR, 4095);
    send(REQ_DATA, 8'h11);
    send(REQ_DATA, 8'h22);
    send(REQ_HDR, 4095);
    send(REQ_DATA, 8'h33);
    send(REQ_HDR, 2);
    send(REQ_DATA, 8'h44);
    send(REQ_DATA, 8'h55);
    send(REQ_READ, 64);
    send(REQ_CLEAR, 0);
    send(REQ_READ, 1);
    send(REQ_HDR, 3);
    send(REQ_DATA, 8'h66);

    foreach (phase_caps[p]) begin
      drain();
      idle_on <= (p != $size(phase_caps) - 1);
      write_capacity(phase_caps[p]);
      send(REQ_DATA, $urandom);
      n = 0;
      while (n < PHASE_ITEMS) begin
        pick = $urandom_range(0, 99);
        if (pick < 50) begin
          len = $urandom_range(1, (cap_eff < 13) ? cap_eff : 12);
          send(REQ_HDR, len);
          n++;
          repeat (len) begin
            send(REQ_DATA, $urandom);
            n++;
          end
        end else if (pick < 75) begin
          r  = $urandom_range(0, 19);
          rl = (r == 0) ? 0 : (r < 3) ? $urandom_range(65, 127) :
               (r < 8) ? $urandom_range(17, 64) : $urandom_range(1, 16);
          send(REQ_READ, rl);
          n++;
        end else if (pick < 85) begin
          send(REQ_HDR, $urandom_range(0, 4095));
          n++;
          repeat ($urandom_range(0, 3)) begin
            send(REQ_DATA, $urandom);
            n++;
          end
        end else if (pick < 90) begin
          send(REQ_DATA, $urandom);
        end else if (pick < 94) begin
          send(REQ_CLEAR, 0);
          n++;
        end else begin
          send(2'($urandom_range(0, 3)), $urandom);
          n++;
        end
      end
    end

    drain();
    $display("Sent %0d requests over %0d capacity settings; compared %0d results.",
             sent, settings + 1, checked);
    if (err_count == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

endmodule

// ===== byte_ring_buffer_records.f =====
+incdir+src
src/brb_pkg.sv
src/brb_ram.sv
src/byte_ring_buffer_records.sv
tb/sv/brb_checker.sv
tb/sv/tb_top.sv
